// ===== hdl/rgbhsl_pkg.sv =====
package rgbhsl_pkg;

    localparam int QW = 8;        // quotient bits of each divider
    localparam int NW = 16;       // numerator width
    localparam int DW = 9;        // divisor width
    localparam int STAGES = QW;   // one quotient bit per cell

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [8:0] hue_degrees;
        logic [7:0] saturation;
        logic [7:0] lightness;
        logic [7:0] alpha_out;
    } hsl_t;

    typedef enum logic [1:0] {
        HUE_RED_POS = 2'd0,
        HUE_RED_NEG = 2'd1,
        HUE_GREEN   = 2'd2,
        HUE_BLUE    = 2'd3
    } hue_sel_t;

    // payload carried alongside a division through the chain
    typedef struct packed {
        logic       valid;
        logic       grey;
        hue_sel_t   sel;
        logic [7:0] lightness;
        logic [7:0] alpha;
    } side_t;

    // partial division state for hue and saturation
    typedef struct packed {
        logic [NW-1:0] hrem;
        logic [DW-1:0] hdiv;
        logic [QW-1:0] hq;
        logic [NW-1:0] srem;
        logic [DW-1:0] sdiv;
        logic [QW-1:0] sq;
    } div_t;

endpackage

// ===== hdl/rgb_to_hsl_converter.sv =====
// RGB to HSL converter, 8 bits per channel.
// Drive pixel and pulse start for one cycle per item; busy is always low,
// so an item may be given in every cycle. Each item yields one result on
// result, marked by done for one cycle, in item order.
// The chain is registered throughout: a prep register takes max, min and the
// numerators, eight cells each resolve one quotient bit of the hue and
// saturation divisions, and an output register takes the hue angle formed
// after the last cell. Throughput is one item per cycle.
// Alpha is carried alongside unchanged.
// Reset clears the valid marks in every cell, so no result is shown until
// an item has passed the chain. The receiver cannot stall; results are
// shown once and must be taken in the cycle they appear.
module rgb_to_hsl_converter
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rgbhsl_pkg::pixel_t  pixel,
    output logic                done,
    output rgbhsl_pkg::hsl_t    result
);

    rgbhsl_pkg::side_t side_c [rgbhsl_pkg::STAGES+1];
    rgbhsl_pkg::div_t  dv_c   [rgbhsl_pkg::STAGES+1];
    rgbhsl_pkg::side_t last;
    rgbhsl_pkg::div_t  lastd;
    logic       done_reg;
    rgbhsl_pkg::hsl_t res_reg, res_next;
    logic [8:0] hue;

    assign busy = 1'b0;

    rgbhsl_prep u_prep
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .pix   (pixel),
        .side  (side_c[0]),
        .dv    (dv_c[0])
    );

    for (genvar i = 0; i < rgbhsl_pkg::STAGES; i++)
    begin : g_cell
        rgbhsl_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .bitpos   (3'(rgbhsl_pkg::STAGES - 1 - i)),
            .side_in  (side_c[i]),
            .dv_in    (dv_c[i]),
            .side_out (side_c[i+1]),
            .dv_out   (dv_c[i+1])
        );
    end

    assign last = side_c[rgbhsl_pkg::STAGES];
    assign lastd = dv_c[rgbhsl_pkg::STAGES];

    always_comb
    begin
        // green and blue quotients carry a +60 bias
        case (last.sel)
            rgbhsl_pkg::HUE_RED_POS: hue = {1'b0, lastd.hq};
            rgbhsl_pkg::HUE_RED_NEG:
                hue = (lastd.hq == 8'd0) ? 9'd0 : 9'(10'd360 - {2'b0, lastd.hq});
            rgbhsl_pkg::HUE_GREEN:   hue = 9'({1'b0, lastd.hq} + 9'd60);
            rgbhsl_pkg::HUE_BLUE:    hue = 9'({1'b0, lastd.hq} + 9'd180);
            default:                 hue = 9'd0;
        endcase
        res_next.hue_degrees = last.grey ? 9'd0 : hue;
        res_next.saturation = last.grey ? 8'd0 : lastd.sq;
        res_next.lightness = last.lightness;
        res_next.alpha_out = last.alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign result = res_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##10 done)
        else $error("item lost in chain");
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.hue_degrees < 9'd360))
        else $error("hue out of range");
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 10))
        else $error("result without item");

endmodule

// ===== hdl/rgbhsl_prep.sv =====
module rgbhsl_prep
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rgbhsl_pkg::pixel_t   pix,
    output rgbhsl_pkg::side_t    side,
    output rgbhsl_pkg::div_t     dv
);

    logic [7:0] mx, mn, dl;
    logic [8:0] s;
    logic [7:0] pos, neg;
    logic [14:0] hnum;
    rgbhsl_pkg::hue_sel_t sel;
    rgbhsl_pkg::side_t side_reg, side_next;
    rgbhsl_pkg::div_t dv_reg, dv_next;

    always_comb
    begin
        mx = pix.red;
        if (pix.green > mx) mx = pix.green;
        if (pix.blue > mx) mx = pix.blue;
        mn = pix.red;
        if (pix.green < mn) mn = pix.green;
        if (pix.blue < mn) mn = pix.blue;
        dl = mx - mn;
        s = {1'b0, mx} + {1'b0, mn};
        // red wins ties, then green
        if (mx == pix.red)
        begin
            if (pix.green >= pix.blue)
            begin
                sel = rgbhsl_pkg::HUE_RED_POS;
                pos = pix.green - pix.blue;
            end
            else
            begin
                sel = rgbhsl_pkg::HUE_RED_NEG;
                pos = pix.blue - pix.green;
            end
            neg = 8'd0;
        end
        else if (mx == pix.green)
        begin
            sel = rgbhsl_pkg::HUE_GREEN;
            pos = pix.blue;
            neg = pix.red;
        end
        else
        begin
            sel = rgbhsl_pkg::HUE_BLUE;
            pos = pix.red;
            neg = pix.green;
        end
        // fractional hue part: 60*(pos-neg)/d lies in -60..60; green and blue bias it by 60*d
        if (sel == rgbhsl_pkg::HUE_GREEN || sel == rgbhsl_pkg::HUE_BLUE)
            hnum = 15'd60 * {7'd0, dl} + 15'd60 * {7'd0, pos} - 15'd60 * {7'd0, neg};
        else
            hnum = 15'd60 * {7'd0, pos};

        side_next.valid = start;
        side_next.grey = (dl == 8'd0);
        side_next.sel = sel;
        side_next.lightness = s[8:1];
        side_next.alpha = pix.alpha;
        dv_next.hrem = {1'b0, hnum};
        dv_next.hdiv = {1'b0, dl};
        dv_next.hq = '0;
        dv_next.srem = 16'd255 * {8'd0, dl};
        dv_next.sdiv = (s < 9'd255) ? s : 9'(10'd510 - {1'b0, s});
        dv_next.sq = '0;
        if (dl == 8'd0)
        begin
            dv_next.hdiv = 9'd1;
            dv_next.sdiv = 9'd1;
            dv_next.hrem = '0;
            dv_next.srem = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else
            side_reg <= side_next;
    end

    always_ff @(posedge clk)
    begin
        dv_reg <= dv_next;
    end

    assign side = side_reg;
    assign dv = dv_reg;

endmodule

// ===== hdl/rgbhsl_cell.sv =====
module rgbhsl_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          bitpos,
    input  rgbhsl_pkg::side_t   side_in,
    input  rgbhsl_pkg::div_t    dv_in,
    output rgbhsl_pkg::side_t   side_out,
    output rgbhsl_pkg::div_t    dv_out
);

    logic [16:0] htrial, strial;
    rgbhsl_pkg::div_t dv_next, dv_reg;
    rgbhsl_pkg::side_t side_reg;

    // restoring division, one quotient bit per cell
    always_comb
    begin
        dv_next = dv_in;
        htrial = {1'b0, dv_in.hdiv, 7'd0} >> (3'd7 - bitpos);
        strial = {1'b0, dv_in.sdiv, 7'd0} >> (3'd7 - bitpos);
        if ({1'b0, dv_in.hrem} >= htrial)
        begin
            dv_next.hrem = 16'({1'b0, dv_in.hrem} - htrial);
            dv_next.hq[bitpos] = 1'b1;
        end
        if ({1'b0, dv_in.srem} >= strial)
        begin
            dv_next.srem = 16'({1'b0, dv_in.srem} - strial);
            dv_next.sq[bitpos] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else
            side_reg <= side_in;
    end

    always_ff @(posedge clk)
    begin
        dv_reg <= dv_next;
    end

    assign side_out = side_reg;
    assign dv_out = dv_reg;

endmodule
